### design/kpd_pkg.sv
// Shared types, constants and key translation tables of the keypad event decoder.
package kpd_pkg;

    localparam int FRAME_LEN     = 8;
    localparam int TABLE_ENTRIES = 56;
    localparam int NUM_SLOTS     = 8;

    localparam logic [7:0]  STATUS_BYTE   = 8'hA5;
    localparam logic [7:0]  TYPE_BYTE     = 8'hB4;
    localparam logic [7:0]  SECOND_BYTE   = 8'hC5;
    localparam logic [7:0]  KEY_OFFSET    = 8'h11;
    localparam logic [15:0] AWAKE_RESET   = 16'd1000;
    localparam logic [2:0]  LAST_POSITION = 3'(FRAME_LEN - 1);

    typedef enum logic [1:0] {
        KIND_KEY   = 2'd0,
        KIND_MOD   = 2'd1,
        KIND_ERR   = 2'd2,
        KIND_AWAKE = 2'd3
    } t_kind;

    // Also zero on results that are not errors.
    typedef enum logic [1:0] {
        ERR_TYPE     = 2'd0,
        ERR_SECOND   = 2'd1,
        ERR_CHECKSUM = 2'd2
    } t_err;

    typedef enum logic [1:0] {
        MAP_PLAIN  = 2'd0,
        MAP_SHIFT  = 2'd1,
        MAP_ORANGE = 2'd2,
        MAP_GREEN  = 2'd3
    } t_map;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] key_code;
        logic [1:0] mod_index;
        logic       pressed;
        logic [6:0] ascii;
        t_err       err;
    } t_result;

    // Results raised by one transaction, in delivery order from slot 0 up.
    typedef struct packed {
        logic [NUM_SLOTS-1:0]          mask;
        t_result [NUM_SLOTS-1:0]       slot;
    } t_batch;

    // Four maps of 8 rows by 8 columns: plain, shift, orange/people, green.
    localparam logic [6:0] KPD_MAP [0:255] = '{
        7'h37, 7'h36, 7'h35, 7'h34, 7'h33, 7'h32, 7'h31, 7'h00,
        7'h75, 7'h79, 7'h74, 7'h72, 7'h65, 7'h77, 7'h71, 7'h00,
        7'h6A, 7'h68, 7'h67, 7'h66, 7'h64, 7'h73, 7'h61, 7'h00,
        7'h6E, 7'h62, 7'h76, 7'h63, 7'h78, 7'h7A, 7'h00, 7'h00,
        7'h09, 7'h6D, 7'h2E, 7'h20, 7'h0B, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h2C, 7'h0A, 7'h70, 7'h30, 7'h39, 7'h38, 7'h00,
        7'h08, 7'h6C, 7'h00, 7'h00, 7'h6F, 7'h69, 7'h6B, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,

        7'h26, 7'h5E, 7'h25, 7'h24, 7'h23, 7'h40, 7'h21, 7'h00,
        7'h55, 7'h59, 7'h54, 7'h52, 7'h45, 7'h57, 7'h51, 7'h00,
        7'h4A, 7'h48, 7'h47, 7'h46, 7'h44, 7'h53, 7'h41, 7'h00,
        7'h4E, 7'h42, 7'h56, 7'h43, 7'h58, 7'h5A, 7'h00, 7'h00,
        7'h09, 7'h4D, 7'h3E, 7'h20, 7'h0B, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h3C, 7'h0A, 7'h50, 7'h29, 7'h28, 7'h2A, 7'h00,
        7'h08, 7'h4C, 7'h00, 7'h00, 7'h4F, 7'h49, 7'h4B, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,

        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h24, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h22, 7'h5C, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h2B, 7'h2D, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h09, 7'h00, 7'h00, 7'h20, 7'h0B, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h3B, 7'h0A, 7'h3D, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h08, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,

        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h26, 7'h5E, 7'h25, 7'h23, 7'h00, 7'h40, 7'h21, 7'h00,
        7'h27, 7'h2F, 7'h00, 7'h7D, 7'h7B, 7'h00, 7'h7E, 7'h00,
        7'h3C, 7'h7C, 7'h5F, 7'h00, 7'h00, 7'h60, 7'h00, 7'h00,
        7'h09, 7'h3E, 7'h3F, 7'h20, 7'h0B, 7'h00, 7'h00, 7'h00,
        7'h00, 7'h3A, 7'h0A, 7'h29, 7'h00, 7'h00, 7'h00, 7'h00,
        7'h08, 7'h5D, 7'h00, 7'h00, 7'h28, 7'h2A, 7'h5B, 7'h00,
        7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00, 7'h00
    };

    // Shift wins, then orange or people, then green, then plain.
    function automatic logic [6:0] kpd_translate(input logic [7:0] code,
                                                 input logic [3:0] mods);
        logic [7:0] d;
        logic [5:0] idx;
        t_map       sel;
        d   = code - KEY_OFFSET;
        idx = {d[6:4], d[2:0]};
        if (mods[0]) begin
            sel = MAP_SHIFT;
        end else if (mods[2] || mods[3]) begin
            sel = MAP_ORANGE;
        end else if (mods[1]) begin
            sel = MAP_GREEN;
        end else begin
            sel = MAP_PLAIN;
        end
        if (idx >= TABLE_ENTRIES) begin
            return 7'd0;
        end
        return KPD_MAP[{sel, idx}];
    endfunction

endpackage

### design/kpd_if.sv
// Valid/ready channel interfaces for received bytes and decoded events.
interface kpd_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] rx_byte;

    modport source (output valid, output command, output rx_byte, input ready);
    modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface kpd_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] event_kind;
    logic [7:0] key_code;
    logic [1:0] modifier_index;
    logic       pressed;
    logic [6:0] ascii_char;
    logic [1:0] error_code;
    logic       last;

    modport source (output valid, output event_kind, output key_code,
                    output modifier_index, output pressed, output ascii_char,
                    output error_code, output last, input ready);
    modport sink   (input valid, input event_kind, input key_code,
                    input modifier_index, input pressed, input ascii_char,
                    input error_code, input last, output ready);
endinterface

### design/kpd_decode.sv
// Frame assembly, frame checks, key/modifier diffing and the keep-awake timer.
module kpd_decode import kpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic        i_command,
    input  logic [7:0]  i_rx_byte,
    input  logic [15:0] i_interval,
    output t_batch      o_batch
);

    logic [2:0]  r_pos,  n_pos;
    logic [3:0]  r_mods, n_mods;
    logic [7:0]  r_key0, n_key0;
    logic [7:0]  r_key1, n_key1;
    logic [15:0] r_ms,   n_ms;
    logic [7:0]  r_frame [0:FRAME_LEN-2];

    logic [16:0] ms_next;
    logic [7:0]  sum;
    logic [3:0]  mods;
    logic [3:0]  changes;
    logic [7:0]  k0, k1;
    t_result     blank;

    always_comb begin
        n_pos   = r_pos;
        n_mods  = r_mods;
        n_key0  = r_key0;
        n_key1  = r_key1;
        n_ms    = r_ms;
        o_batch = '0;
        blank   = '{kind: KIND_KEY, key_code: 8'd0, mod_index: 2'd0, pressed: 1'b0,
                    ascii: 7'd0, err: ERR_TYPE};
        ms_next = {1'b0, r_ms} + 17'd1;
        sum     = 8'd0;
        for (int i = 0; i < FRAME_LEN - 1; i++) begin
            sum = sum + r_frame[i];
        end
        mods    = r_frame[3][3:0];
        changes = mods ^ r_mods;
        k0      = r_frame[4];
        k1      = r_frame[5];
        for (int i = 0; i < NUM_SLOTS; i++) begin
            o_batch.slot[i] = blank;
        end

        if (i_command) begin
            if (ms_next > {1'b0, i_interval}) begin
                n_ms                 = 16'd0;
                o_batch.mask[0]      = 1'b1;
                o_batch.slot[0].kind = KIND_AWAKE;
            end else begin
                n_ms = ms_next[15:0];
            end
        end else if (r_pos != LAST_POSITION) begin
            n_pos = r_pos + 3'd1;
        end else begin
            // Closing byte: check the frame and diff against held state.
            n_pos = 3'd0;
            if (r_frame[0] == STATUS_BYTE) begin
                o_batch.mask = '0;
            end else if (r_frame[0] != TYPE_BYTE) begin
                o_batch.mask[0]      = 1'b1;
                o_batch.slot[0].kind = KIND_ERR;
                o_batch.slot[0].err  = ERR_TYPE;
            end else if (r_frame[1] != SECOND_BYTE) begin
                o_batch.mask[0]      = 1'b1;
                o_batch.slot[0].kind = KIND_ERR;
                o_batch.slot[0].err  = ERR_SECOND;
            end else if (8'd0 - sum != i_rx_byte) begin
                o_batch.mask[0]      = 1'b1;
                o_batch.slot[0].kind = KIND_ERR;
                o_batch.slot[0].err  = ERR_CHECKSUM;
            end else begin
                for (int i = 0; i < 4; i++) begin
                    o_batch.mask[i]           = changes[i];
                    o_batch.slot[i].kind      = KIND_MOD;
                    o_batch.slot[i].mod_index = 2'(i);
                    o_batch.slot[i].pressed   = mods[i];
                end
                o_batch.mask[4] = (k0 != 8'd0) && (k0 != r_key0) && (k0 != r_key1);
                o_batch.mask[5] = (k1 != 8'd0) && (k1 != r_key0) && (k1 != r_key1);
                o_batch.mask[6] = (r_key0 != 8'd0) && (r_key0 != k0) && (r_key0 != k1);
                o_batch.mask[7] = (r_key1 != 8'd0) && (r_key1 != k0) && (r_key1 != k1);
                o_batch.slot[4].key_code = k0;
                o_batch.slot[5].key_code = k1;
                o_batch.slot[6].key_code = r_key0;
                o_batch.slot[7].key_code = r_key1;
                o_batch.slot[4].pressed  = 1'b1;
                o_batch.slot[5].pressed  = 1'b1;
                o_batch.slot[4].ascii    = kpd_translate(k0, mods);
                o_batch.slot[5].ascii    = kpd_translate(k1, mods);
                o_batch.slot[6].ascii    = kpd_translate(r_key0, mods);
                o_batch.slot[7].ascii    = kpd_translate(r_key1, mods);
                n_mods = mods;
                n_key0 = k0;
                n_key1 = k1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 3'd0;
            r_mods <= 4'd0;
            r_key0 <= 8'd0;
            r_key1 <= 8'd0;
            r_ms   <= 16'd0;
        end else if (i_accept) begin
            r_pos  <= n_pos;
            r_mods <= n_mods;
            r_key0 <= n_key0;
            r_key1 <= n_key1;
            r_ms   <= n_ms;
        end
    end

    // Byte store: the closing byte is used straight from the input.
    always_ff @(posedge i_clk) begin
        if (i_accept && !i_command && r_pos != LAST_POSITION) begin
            r_frame[r_pos] <= i_rx_byte;
        end
    end

endmodule

### design/kpd_emit.sv
// Pending result list and output register; drains one result per cycle while the output is not stalled.
module kpd_emit import kpd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  t_batch            i_batch,
    output logic              o_in_ready,
    kpd_out_if.source         out_ch
);

    logic [NUM_SLOTS-1:0]    r_mask, n_mask;
    t_result [NUM_SLOTS-1:0] r_slot;
    logic                    r_valid;
    t_result                 r_res;
    logic                    r_last;

    logic [NUM_SLOTS-1:0]    pick;
    logic [NUM_SLOTS-1:0]    remain;
    logic                    move;
    t_result                 picked;

    always_comb begin
        pick   = r_mask & (~r_mask + 1'b1);
        remain = r_mask & ~pick;
        move   = (r_mask != '0) && (!r_valid || out_ch.ready);
        picked = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (pick[i]) begin
                picked = picked | r_slot[i];
            end
        end
    end

    // Ready once the list empties in this cycle; a new batch replaces it.
    assign o_in_ready = move ? (remain == '0) : (r_mask == '0);
    assign n_mask     = i_accept ? i_batch.mask : (move ? remain : r_mask);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (move) begin
                r_valid <= 1'b1;
            end else if (out_ch.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_slot <= i_batch.slot;
        end
        if (move) begin
            r_res  <= picked;
            r_last <= (remain == '0);
        end
    end

    assign out_ch.valid          = r_valid;
    assign out_ch.event_kind     = r_res.kind;
    assign out_ch.key_code       = r_res.key_code;
    assign out_ch.modifier_index = r_res.mod_index;
    assign out_ch.pressed        = r_res.pressed;
    assign out_ch.ascii_char     = r_res.ascii;
    assign out_ch.error_code     = r_res.err;
    assign out_ch.last           = r_last;

endmodule

### design/keypad_packet_key_event_decoder.sv
// Top level of the keypad serial-link key event decoder.
// Usage:
//   in_ch carries one transaction per received byte (command 0) or per
//   millisecond tick (command 1). out_ch carries decoded events: modifier
//   changes, key down, key up, frame errors and keep-awake requests, with
//   last set on the final event raised by one input transaction.
//   The APB port holds one register, awake_interval_ms, at address 0.
//   Write it only while the block is idle.
// Event path:
//   An event passes from the input through the pending list into the
//   output register. Inputs raising zero or one event are taken every
//   cycle while out_ch.ready stays high. The closing byte of a frame queues
//   up to eight events, drained one a cycle through the output register
//   while out_ch.ready is high; the next input is held off until the last
//   of them moves into the output register.
// Reset: synchronous, active low. Frame position, held keys and modifiers
//   and the tick count clear; the interval returns to 1000. Stored frame
//   bytes are not cleared.
// Stalls: while out_ch.ready is low the output holds; inputs are still
//   taken while the pending list is empty, and held off once it holds an event.
module keypad_packet_key_event_decoder import kpd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    kpd_in_if.sink      in_ch,
    kpd_out_if.source   out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_interval;
    logic        accept;
    logic        in_ready;
    t_batch      batch;

    // Register index is the word address; only index 0 exists.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= AWAKE_RESET;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_interval <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {16'd0, r_interval} : 32'd0;

    // Take a transaction only when the pending list will be empty.
    assign in_ch.ready = in_ready;
    assign accept      = in_ch.valid && in_ready;

    kpd_decode u_decode (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_command  (in_ch.command),
        .i_rx_byte  (in_ch.rx_byte),
        .i_interval (r_interval),
        .o_batch    (batch)
    );

    kpd_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_batch    (batch),
        .o_in_ready (in_ready),
        .out_ch     (out_ch)
    );

endmodule

### verif/tb.sv
// Testbench for the keypad key event decoder: frame stimulus, event prediction and checks.
`timescale 1ns / 100ps

module tb;
    import kpd_pkg::*;

    localparam logic [2:0] ADDR_AWAKE  = 3'd0;
    localparam logic [2:0] ADDR_UNUSED = 3'd4;
    localparam int         PHASE_ITEMS = 40;
    localparam int         SETTLE      = 16;

    // One decoded event as it leaves the block.
    typedef struct packed {
        t_kind      kind;
        logic [7:0] key_code;
        logic [1:0] mod_index;
        logic       pressed;
        logic [6:0] ascii;
        logic [1:0] err;
        logic       last;
    } t_kpd_event;

    // Eight frame bytes, byte i at bits 8*i+7..8*i.
    typedef logic [63:0] t_frame;

    typedef enum int {
        FR_GOOD,
        FR_STATUS,
        FR_BAD_TYPE,
        FR_BAD_SECOND,
        FR_BAD_SUM,
        FR_GARBAGE
    } t_frame_kind;

    // Decoder state mirror plus the queue of events still owed by the block.
    class kpd_event_board;
        logic [15:0] interval;
        logic [2:0]  frame_pos;
        logic [7:0]  frame_buf [8];
        logic [3:0]  held_mods;
        logic [7:0]  key_a;
        logic [7:0]  key_b;
        logic [15:0] ms_count;
        logic [6:0]  char_tbl [256];
        t_kpd_event  owed [$];
        t_kpd_event  fresh [$];
        int          errors;

        function new();
            string rows [4];
            logic [7:0] c;
            // A blank stands for no character; the shared control cells are patched below.
            rows[0] = {"7654321 ", "uytrewq ", "jhgfdsa ", "nbvcxz  ",
                       " m.     ", " , p098 ", " l  oik ", "        "};
            rows[1] = {"&^%$#@! ", "UYTREWQ ", "JHGFDSA ", "NBVCXZ  ",
                       " M>     ", " < P)(* ", " L  OIK ", "        "};
            rows[2] = {"        ", "   $    ", "\"\\      ", " +-     ",
                       "        ", " ; =    ", "        ", "        "};
            rows[3] = {"        ", "&^%# @! ", "'/ }{ ~ ", "<|_  `  ",
                       " >?     ", " : )    ", " ]  (*[ ", "        "};
            for (int t = 0; t < 4; t++) begin
                for (int i = 0; i < 64; i++) begin
                    c = rows[t][i];
                    char_tbl[t * 64 + i] = (c == 8'h20) ? 7'd0 : c[6:0];
                end
                char_tbl[t * 64 + 32] = 7'd9;
                char_tbl[t * 64 + 35] = 7'h20;
                char_tbl[t * 64 + 36] = 7'd11;
                char_tbl[t * 64 + 42] = 7'd10;
                char_tbl[t * 64 + 48] = 7'd8;
            end
            interval  = AWAKE_RESET;
            frame_pos = '0;
            for (int i = 0; i < 8; i++) frame_buf[i] = '0;
            held_mods = '0;
            key_a     = '0;
            key_b     = '0;
            ms_count  = '0;
            errors    = 0;
        endfunction

        function void set_interval(logic [15:0] v);
            interval = v;
        endfunction

        function int pending();
            return owed.size();
        endfunction

        function void add(t_kind kind, logic [7:0] code, logic [1:0] mi, logic down,
                          logic [6:0] ch, t_err err);
            t_kpd_event ev;
            ev.kind      = kind;
            ev.key_code  = code;
            ev.mod_index = mi;
            ev.pressed   = down;
            ev.ascii     = ch;
            ev.err       = err;
            ev.last      = 1'b0;
            fresh.push_back(ev);
        endfunction

        // Shift wins, then orange or people, then green, then plain.
        function logic [6:0] to_ascii(logic [7:0] code);
            logic [7:0] d;
            logic [5:0] idx;
            logic [1:0] sel;
            d   = code - KEY_OFFSET;
            idx = {d[6:4], d[2:0]};
            if (idx >= TABLE_ENTRIES) return 7'd0;
            if (held_mods[0])
                sel = MAP_SHIFT;
            else if (held_mods[2] || held_mods[3])
                sel = MAP_ORANGE;
            else if (held_mods[1])
                sel = MAP_GREEN;
            else
                sel = MAP_PLAIN;
            return char_tbl[{sel, idx}];
        endfunction

        function void close_frame();
            logic [7:0] sum;
            logic [3:0] mods;
            logic [3:0] changed;
            logic [7:0] k0, k1, o0, o1;
            if (frame_buf[0] == STATUS_BYTE) return;
            if (frame_buf[0] != TYPE_BYTE) begin
                add(KIND_ERR, 8'd0, 2'd0, 1'b0, 7'd0, ERR_TYPE);
                return;
            end
            if (frame_buf[1] != SECOND_BYTE) begin
                add(KIND_ERR, 8'd0, 2'd0, 1'b0, 7'd0, ERR_SECOND);
                return;
            end
            sum = '0;
            for (int i = 0; i < 7; i++) sum = sum + frame_buf[i];
            if (8'(8'd0 - sum) != frame_buf[7]) begin
                add(KIND_ERR, 8'd0, 2'd0, 1'b0, 7'd0, ERR_CHECKSUM);
                return;
            end
            // Upper nibble of the modifier byte carries nothing.
            mods    = frame_buf[3][3:0];
            changed = mods ^ held_mods;
            for (int i = 0; i < 4; i++) begin
                if (changed[i]) add(KIND_MOD, 8'd0, 2'(i), mods[i], 7'd0, ERR_TYPE);
            end
            held_mods = mods;
            k0 = frame_buf[4];
            k1 = frame_buf[5];
            o0 = key_a;
            o1 = key_b;
            if (k0 != 0 && k0 != o0 && k0 != o1)
                add(KIND_KEY, k0, 2'd0, 1'b1, to_ascii(k0), ERR_TYPE);
            if (k1 != 0 && k1 != o0 && k1 != o1)
                add(KIND_KEY, k1, 2'd0, 1'b1, to_ascii(k1), ERR_TYPE);
            if (o0 != 0 && o0 != k0 && o0 != k1)
                add(KIND_KEY, o0, 2'd0, 1'b0, to_ascii(o0), ERR_TYPE);
            if (o1 != 0 && o1 != k0 && o1 != k1)
                add(KIND_KEY, o1, 2'd0, 1'b0, to_ascii(o1), ERR_TYPE);
            key_a = k0;
            key_b = k1;
        endfunction

        // Advance the mirror by one accepted transaction and queue what it owes.
        function void take_input(logic cmd, logic [7:0] rx);
            t_kpd_event ev;
            logic [16:0] next;
            fresh.delete();
            if (cmd) begin
                next = {1'b0, ms_count} + 17'd1;
                if (next > {1'b0, interval}) begin
                    ms_count = '0;
                    add(KIND_AWAKE, 8'd0, 2'd0, 1'b0, 7'd0, ERR_TYPE);
                end else begin
                    ms_count = next[15:0];
                end
            end else begin
                frame_buf[frame_pos] = rx;
                if (frame_pos == LAST_POSITION) begin
                    frame_pos = '0;
                    close_frame();
                end else begin
                    frame_pos = frame_pos + 3'd1;
                end
            end
            if (fresh.size() > 0) begin
                ev = fresh[fresh.size() - 1];
                ev.last = 1'b1;
                fresh[fresh.size() - 1] = ev;
            end
            foreach (fresh[i]) owed.push_back(fresh[i]);
        endfunction

        function void field_check(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        // Compare one delivered event against the oldest owed one.
        function void match_event(t_kpd_event got);
            t_kpd_event want;
            if (owed.size() == 0) begin
                $display("%0t: event kind %0d key %0h with nothing expected", $time,
                         got.kind, got.key_code);
                errors++;
                return;
            end
            want = owed.pop_front();
            field_check("event_kind", want.kind, got.kind);
            field_check("key_code", want.key_code, got.key_code);
            field_check("modifier_index", want.mod_index, got.mod_index);
            field_check("pressed", want.pressed, got.pressed);
            field_check("ascii_char", want.ascii, got.ascii);
            field_check("error_code", want.err, got.err);
            field_check("last", want.last, got.last);
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    kpd_in_if  in_if ();
    kpd_out_if out_if ();

    kpd_event_board sb;
    int             items_sent;
    bit             steady;

    keypad_packet_key_event_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Key codes lean on the held keys so that presses, holds and releases all occur.
    function automatic logic [7:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) return 8'd0;
        if (r < 45) return sb.key_a;
        if (r < 65) return sb.key_b;
        if (r < 90) return KEY_OFFSET + {1'b0, 3'($urandom), 1'b0, 3'($urandom)};
        return 8'($urandom);
    endfunction

    function automatic t_frame build_frame(logic [7:0] b0, logic [7:0] b1, logic [7:0] b2,
                                           logic [7:0] b3, logic [7:0] b4, logic [7:0] b5,
                                           logic [7:0] b6);
        logic [7:0] sum;
        sum = b0 + b1 + b2 + b3 + b4 + b5 + b6;
        return {8'(8'd0 - sum), b6, b5, b4, b3, b2, b1, b0};
    endfunction

    // Offer one transaction, hold it until taken, then idle for a while.
    task automatic send_item(logic cmd, logic [7:0] rx);
        int gap;
        @(negedge i_clk);
        in_if.valid   <= 1'b1;
        in_if.command <= cmd;
        in_if.rx_byte <= rx;
        @(posedge i_clk);
        while (in_if.ready !== 1'b1) @(posedge i_clk);
        sb.take_input(cmd, rx);
        items_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            in_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic send_tick();
        send_item(1'b1, 8'($urandom));
    endtask

    // Ticks may land between the bytes of a frame; they leave the frame position alone.
    task automatic send_frame(t_frame f);
        for (int i = 0; i < 8; i++) begin
            if (!steady && $urandom_range(0, 99) < 6) send_tick();
            send_item(1'b0, f[8 * i +: 8]);
        end
    endtask

    task automatic send_random_frame();
        int          r;
        t_frame_kind kind;
        t_frame      f;
        logic [7:0]  mods;
        logic [7:0]  b0;
        logic [7:0]  b1;
        r = $urandom_range(0, 99);
        if (r < 55)      kind = FR_GOOD;
        else if (r < 63) kind = FR_STATUS;
        else if (r < 73) kind = FR_BAD_TYPE;
        else if (r < 83) kind = FR_BAD_SECOND;
        else if (r < 93) kind = FR_BAD_SUM;
        else             kind = FR_GARBAGE;
        if ($urandom_range(0, 9) < 3) mods = {4'($urandom), sb.held_mods};
        else                          mods = 8'($urandom);
        f = build_frame(TYPE_BYTE, SECOND_BYTE, 8'($urandom), mods, pick_key(), pick_key(),
                        8'($urandom));
        case (kind)
            FR_STATUS: begin
                f[7:0] = STATUS_BYTE;
            end
            FR_BAD_TYPE: begin
                b0 = 8'($urandom);
                while (b0 == TYPE_BYTE || b0 == STATUS_BYTE) b0 = 8'($urandom);
                f[7:0] = b0;
            end
            FR_BAD_SECOND: begin
                b1 = 8'($urandom);
                while (b1 == SECOND_BYTE) b1 = 8'($urandom);
                f[15:8] = b1;
            end
            FR_BAD_SUM: begin
                f[63:56] = f[63:56] ^ 8'($urandom_range(1, 255));
            end
            default: ;
        endcase
        if (kind == FR_GARBAGE) begin
            // Broken sequence: a few loose bytes knock the framing out of step.
            repeat ($urandom_range(1, 7)) send_item(1'b0, 8'($urandom));
        end else begin
            send_frame(f);
        end
    endtask

    // Hold the input low until every owed event has come out, then let the block settle.
    task automatic wait_drained();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic apb_access(logic wr, logic [2:0] addr, logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        rdata = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic readback_interval();
        logic [31:0] rd;
        apb_access(1'b0, ADDR_AWAKE, 32'd0, rd);
        if (rd[15:0] !== sb.interval) begin
            $display("%0t: awake_interval_ms readback mismatch, expected %0h, actual %0h",
                     $time, sb.interval, rd[15:0]);
            sb.errors++;
        end
    endtask

    task automatic set_awake_interval(logic [15:0] v);
        logic [31:0] unused_rd;
        apb_access(1'b1, ADDR_AWAKE, {16'($urandom), v}, unused_rd);
        sb.set_interval(v);
        readback_interval();
    endtask

    // Sink side: random back-pressure on the event channel.
    initial begin
        int stall;
        out_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            out_if.ready <= 1'b1;
            repeat ($urandom_range(0, 24)) @(negedge i_clk);
            stall = pick_gap();
            if (stall > 0) begin
                @(negedge i_clk);
                out_if.ready <= 1'b0;
                repeat (stall - 1) @(negedge i_clk);
            end
        end
    end

    // Check every event taken by the sink.
    always @(posedge i_clk) begin : event_monitor
        t_kpd_event seen;
        if (i_rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            seen.kind      = t_kind'(out_if.event_kind);
            seen.key_code  = out_if.key_code;
            seen.mod_index = out_if.modifier_index;
            seen.pressed   = out_if.pressed;
            seen.ascii     = out_if.ascii_char;
            seen.err       = out_if.error_code;
            seen.last      = out_if.last;
            sb.match_event(seen);
        end
    end

    initial begin
        logic [15:0] settings [5];
        logic [31:0] unused_rd;
        int          phase_end;

        sb            = new();
        items_sent    = 0;
        steady        = 1'b0;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        in_if.valid   = 1'b0;
        in_if.command = 1'b0;
        in_if.rx_byte = '0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset value, then a write to an unknown register index that must change nothing.
        readback_interval();
        apb_access(1'b1, ADDR_UNUSED, 32'($urandom), unused_rd);
        readback_interval();

        // All modifiers down with the upper nibble set, top and bottom key codes.
        send_frame(build_frame(TYPE_BYTE, SECOND_BYTE, 8'h00, 8'hFF, 8'hFF, KEY_OFFSET, 8'hFF));
        // Everything up; the second key moves to the first slot and stays held.
        send_frame(build_frame(TYPE_BYTE, SECOND_BYTE, 8'hFF, 8'h00, KEY_OFFSET, 8'h00, 8'h00));
        // Status report: dropped without an event.
        send_frame(build_frame(STATUS_BYTE, 8'h00, 8'h5A, 8'h0F, 8'h22, 8'h33, 8'h44));
        send_frame(build_frame(TYPE_BYTE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

        // Zero interval first, then the other extremes, then small random settings.
        settings[0] = 16'd0;
        settings[1] = 16'd1;
        settings[2] = 16'hFFFF;
        settings[3] = 16'($urandom_range(2, 12));
        settings[4] = 16'($urandom_range(2, 40));

        for (int ph = 0; ph < 5; ph++) begin
            wait_drained();
            set_awake_interval(settings[ph]);
            steady    = (ph == 3);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) begin
                if ($urandom_range(0, 99) < 12) begin
                    repeat ($urandom_range(1, 6)) send_tick();
                end else begin
                    // Realign most of the time so that well-formed frames reach decoding.
                    if (sb.frame_pos != 0 && $urandom_range(0, 9) < 9) begin
                        while (sb.frame_pos != 0) send_item(1'b0, 8'($urandom));
                    end
                    send_random_frame();
                end
            end
        end
        steady = 1'b0;

        wait_drained();
        if (sb.errors == 0) begin
            $display("keypad_packet_key_event_decoder test passed");
        end else begin
            $display("keypad_packet_key_event_decoder test failed");
        end
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #4000000;
        $display("keypad_packet_key_event_decoder test failed");
        $finish;
    end

endmodule
